/* rtl/sps_pkg.sv */
package sps_pkg;

    localparam int MAX_SENSORS_DEF = 16;
    localparam logic [31:0] DEFAULT_TICK_MS = 32'd100;
    localparam logic [31:0] DIVIDER_LIMIT = 32'h0000_FFFF;
    localparam int RESULT_LIMIT = 16;

    typedef enum logic [2:0] {
        CMD_REGISTER = 3'd0,
        CMD_START    = 3'd1,
        CMD_TICK     = 3'd2,
        CMD_DREADY   = 3'd3,
        CMD_POLL     = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_STARTED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_BADARG   = 3'd3,
        ST_RANGE    = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_NOTREADY = 3'd6
    } t_status;

    localparam logic [1:0] MODE_PERIODIC = 2'd0;
    localparam logic [1:0] MODE_DREADY   = 2'd1;
    localparam logic [1:0] MODE_FREE     = 2'd2;
    localparam logic [1:0] MODE_BAD      = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD_SCAN,
        S_GCD_RUN,
        S_DIV_SCAN,
        S_DIV_RUN,
        S_MOD_RUN,
        S_DIV_WRITE,
        S_TICK_SCAN,
        S_RESULT
    } t_state;

    // divide unit control
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [31:0] rem;
    } t_div_rsp;

endpackage

/* rtl/sensor_poll_scheduler.sv */
// channel  | valid / ready              | payload
// request  | i_valid / o_ready          | i_command i_poll_mode i_period_ms i_present
//          |                            | i_sensor_index
// result   | o_valid / i_ready          | o_kind o_status o_slot o_base_tick_ms o_last
// register, data ready, poll once and bad commands: result valid the cycle after acceptance
// start: for each periodic sensor after the first, a gcd loop with one divide per remainder;
//   then one divide plus one modulo per periodic sensor, all on the shared divider
// tick: one table entry per cycle, stalled while a poll result waits on i_ready
// reset clears count, started and tick; the tables hold garbage until written
// o_ready is low from acceptance until the command ends and its last result, if any, is taken
module sensor_poll_scheduler #(
    parameter int MAX_SENSORS = sps_pkg::MAX_SENSORS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [1:0]  i_poll_mode,
    input  logic [31:0] i_period_ms,
    input  logic        i_present,
    input  logic [3:0]  i_sensor_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [2:0]  o_status,
    output logic [3:0]  o_slot,
    output logic [31:0] o_base_tick_ms,
    output logic        o_last
);
    import sps_pkg::*;

    localparam int IW = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int CW = $clog2(MAX_SENSORS + 1);
    localparam int NW = $clog2(RESULT_LIMIT + 1);

    logic [1:0]  r_mode   [MAX_SENSORS];
    logic [31:0] r_period [MAX_SENSORS];
    logic        r_pres   [MAX_SENSORS];
    logic [15:0] r_divtab [MAX_SENSORS];
    logic [15:0] r_phase  [MAX_SENSORS];

    t_state      r_state, n_state;
    logic [CW-1:0] r_count;
    logic        r_started;
    logic [31:0] r_tick;
    logic [CW-1:0] r_idx;
    logic [31:0] r_acc;
    logic [31:0] r_b;
    logic [15:0] r_quot;
    logic [NW-1:0] r_npoll;
    logic        r_found;
    logic [IW-1:0] r_found_idx;
    logic        r_kind;
    logic [2:0]  r_status;
    logic [3:0]  r_slot;
    logic [31:0] r_obt;
    logic        r_last;
    logic        r_valid;

    t_div_req    w_req;
    t_div_rsp    w_rsp;
    logic [IW-1:0] w_i;
    logic        w_accept, w_take, w_hit;
    logic [15:0] w_ph1;

    sps_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    assign w_i      = r_idx[IW-1:0];
    assign w_accept = i_valid && o_ready;
    assign w_take   = r_valid && i_ready;
    assign w_ph1    = r_phase[w_i] + 16'd1;
    assign w_hit    = r_pres[w_i] && (r_mode[w_i] != MODE_DREADY)
                      && ((r_mode[w_i] != MODE_PERIODIC) || (w_ph1 >= r_divtab[w_i]));

    assign o_ready        = (r_state == S_IDLE) && !r_valid;
    assign o_valid        = r_valid;
    assign o_kind         = r_kind;
    assign o_status       = r_status;
    assign o_slot         = r_slot;
    assign o_base_tick_ms = r_obt;
    assign o_last         = r_last;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command == CMD_START && !r_started) begin
                        n_state = S_GCD_SCAN;
                    end else if (i_command == CMD_TICK && r_started) begin
                        n_state = S_TICK_SCAN;
                    end
                end
            end
            S_GCD_SCAN: begin
                if (r_idx == r_count) begin
                    n_state = S_DIV_SCAN;
                end else if (r_mode[w_i] == MODE_PERIODIC && r_acc != '0
                             && r_period[w_i] != '0) begin
                    n_state = S_GCD_RUN;
                end
            end
            S_GCD_RUN: begin
                if (w_rsp.done && w_rsp.rem == '0) begin
                    n_state = S_GCD_SCAN;
                end
            end
            S_DIV_SCAN: begin
                if (r_idx == r_count) begin
                    n_state = S_RESULT;
                end else if (r_mode[w_i] == MODE_PERIODIC) begin
                    n_state = S_DIV_RUN;
                end
            end
            S_DIV_RUN: begin
                if (w_rsp.done) begin
                    if (w_rsp.quot > DIVIDER_LIMIT) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_MOD_RUN;
                    end
                end
            end
            S_MOD_RUN: begin
                if (w_rsp.done) begin
                    n_state = S_DIV_WRITE;
                end
            end
            S_DIV_WRITE: n_state = S_DIV_SCAN;
            S_TICK_SCAN: begin
                if (r_found && !(r_valid && !i_ready)) begin
                    n_state = S_TICK_SCAN;
                end
                if (r_idx == r_count && !r_found && !r_valid) begin
                    n_state = S_IDLE;
                end
            end
            S_RESULT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // divider requests
    always_comb begin
        w_req = '0;
        case (r_state)
            S_GCD_SCAN: begin
                if (r_idx != r_count && r_mode[w_i] == MODE_PERIODIC && r_acc != '0
                    && r_period[w_i] != '0) begin
                    w_req.start    = 1'b1;
                    w_req.dividend = r_acc;
                    w_req.divisor  = r_period[w_i];
                end
            end
            S_GCD_RUN: begin
                if (w_rsp.done && w_rsp.rem != '0) begin
                    w_req.start    = 1'b1;
                    w_req.dividend = r_b;
                    w_req.divisor  = w_rsp.rem;
                end
            end
            S_DIV_SCAN: begin
                if (r_idx != r_count && r_mode[w_i] == MODE_PERIODIC) begin
                    w_req.start    = 1'b1;
                    w_req.dividend = r_period[w_i];
                    w_req.divisor  = r_tick;
                end
            end
            S_DIV_RUN: begin
                if (w_rsp.done && w_rsp.quot <= DIVIDER_LIMIT) begin
                    w_req.start    = 1'b1;
                    w_req.dividend = {{(32-CW){1'b0}}, r_idx};
                    w_req.divisor  = (w_rsp.quot == '0) ? 32'd1 : w_rsp.quot;
                end
            end
            default: w_req = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_started <= 1'b0;
            r_tick    <= '0;
            r_valid   <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_take) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind   <= 1'b0;
                        r_slot   <= '0;
                        r_obt    <= '0;
                        r_last   <= 1'b1;
                        r_idx    <= '0;
                        r_acc    <= '0;
                        r_npoll  <= '0;
                        r_found  <= 1'b0;
                        r_status <= ST_OK;
                        case (i_command)
                            CMD_REGISTER: begin
                                r_valid <= 1'b1;
                                if (r_started) begin
                                    r_status <= ST_STARTED;
                                end else if (r_count >= CW'(MAX_SENSORS)) begin
                                    r_status <= ST_FULL;
                                end else if (i_poll_mode == MODE_BAD
                                    || (i_poll_mode == MODE_PERIODIC && i_period_ms == '0)) begin
                                    r_status <= ST_BADARG;
                                end else begin
                                    r_mode[r_count[IW-1:0]]   <= i_poll_mode;
                                    r_period[r_count[IW-1:0]] <= i_period_ms;
                                    r_pres[r_count[IW-1:0]]   <= i_present;
                                    r_slot  <= 4'(r_count);
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            CMD_START: begin
                                if (r_started) begin
                                    r_valid  <= 1'b1;
                                    r_status <= ST_STARTED;
                                    r_obt    <= r_tick;
                                end
                            end
                            CMD_TICK: begin
                                if (!r_started) begin
                                    r_valid  <= 1'b1;
                                    r_status <= ST_NOTREADY;
                                end
                            end
                            CMD_DREADY, CMD_POLL: begin
                                r_valid <= 1'b1;
                                if (32'(i_sensor_index) >= 32'(r_count)) begin
                                    r_status <= ST_NOTFOUND;
                                end else if (!r_started || !r_pres[IW'(i_sensor_index)]) begin
                                    r_status <= ST_NOTREADY;
                                end else begin
                                    r_kind <= 1'b1;
                                    r_slot <= i_sensor_index;
                                end
                            end
                            default: begin
                                r_valid  <= 1'b1;
                                r_status <= ST_BADARG;
                            end
                        endcase
                    end
                end
                S_GCD_SCAN: begin
                    if (r_idx == r_count) begin
                        r_tick <= (r_acc != '0) ? r_acc : DEFAULT_TICK_MS;
                        r_idx  <= '0;
                    end else if (r_mode[w_i] == MODE_PERIODIC) begin
                        if (r_acc == '0) begin
                            r_acc <= r_period[w_i];
                            r_idx <= r_idx + CW'(1);
                        end else if (r_period[w_i] == '0) begin
                            r_idx <= r_idx + CW'(1);
                        end else begin
                            r_b <= r_period[w_i];
                        end
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_GCD_RUN: begin
                    if (w_rsp.done) begin
                        if (w_rsp.rem == '0) begin
                            r_acc <= r_b;
                            r_idx <= r_idx + CW'(1);
                        end else begin
                            r_b <= w_rsp.rem;
                        end
                    end
                end
                S_DIV_SCAN: begin
                    if (r_idx == r_count) begin
                        r_started <= 1'b1;
                        r_valid   <= 1'b1;
                        r_status  <= ST_OK;
                        r_obt     <= r_tick;
                    end else if (r_mode[w_i] != MODE_PERIODIC) begin
                        r_divtab[w_i] <= 16'd1;
                        r_phase[w_i]  <= '0;
                        r_idx         <= r_idx + CW'(1);
                    end
                end
                S_DIV_RUN: begin
                    if (w_rsp.done) begin
                        r_quot <= w_rsp.quot[15:0];
                        if (w_rsp.quot > DIVIDER_LIMIT) begin
                            r_valid  <= 1'b1;
                            r_status <= ST_RANGE;
                            r_slot   <= 4'(r_idx);
                            r_obt    <= r_tick;
                        end
                    end
                end
                S_MOD_RUN: begin
                    if (w_rsp.done) begin
                        r_b <= w_rsp.rem;
                    end
                end
                S_DIV_WRITE: begin
                    r_divtab[w_i] <= r_quot;
                    r_phase[w_i]  <= r_b[15:0];
                    r_idx         <= r_idx + CW'(1);
                end
                S_TICK_SCAN: begin
                    // hold one found poll until the scan shows whether it is the last
                    if (!(r_valid && !i_ready)) begin
                        if (r_idx != r_count) begin
                            if (r_pres[w_i] && r_mode[w_i] == MODE_PERIODIC) begin
                                r_phase[w_i] <= w_hit ? 16'd0 : w_ph1;
                            end
                            r_idx <= r_idx + CW'(1);
                            if (w_hit && r_npoll != NW'(RESULT_LIMIT)) begin
                                r_npoll     <= r_npoll + NW'(1);
                                r_found     <= 1'b1;
                                r_found_idx <= w_i;
                                if (r_found) begin
                                    r_valid  <= 1'b1;
                                    r_kind   <= 1'b1;
                                    r_status <= ST_OK;
                                    r_slot   <= 4'(r_found_idx);
                                    r_last   <= 1'b0;
                                end
                            end
                        end else if (r_found) begin
                            r_found  <= 1'b0;
                            r_valid  <= 1'b1;
                            r_kind   <= 1'b1;
                            r_status <= ST_OK;
                            r_slot   <= 4'(r_found_idx);
                            r_last   <= 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* rtl/sps_divider.sv */
module sps_divider (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sps_pkg::t_div_req i_req,
    output sps_pkg::t_div_rsp o_rsp
);
    import sps_pkg::*;

    logic [31:0] r_quot, n_quot;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_divisor, n_divisor;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_trial;

    // restoring division, one quotient bit per cycle
    always_comb begin
        n_quot    = r_quot;
        n_rem     = r_rem;
        n_divisor = r_divisor;
        n_cnt     = r_cnt;
        n_busy    = r_busy;
        n_done    = 1'b0;
        w_trial   = {r_rem, r_quot[31]} - {1'b0, r_divisor};
        if (i_req.start) begin
            n_quot    = i_req.dividend;
            n_rem     = '0;
            n_divisor = i_req.divisor;
            n_cnt     = 6'd32;
            n_busy    = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                n_rem  = w_trial[31:0];
                n_quot = {r_quot[30:0], 1'b1};
            end else begin
                n_rem  = {r_rem[30:0], r_quot[31]};
                n_quot = {r_quot[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot    <= n_quot;
        r_rem     <= n_rem;
        r_divisor <= n_divisor;
        r_cnt     <= n_cnt;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule
